// ===== design/qfe_pkg.sv =====
// qfe_pkg: shared widths, register codes and control structs for the
// quadratic feature expansion block. No dependencies.
package qfe_pkg;

    localparam int unsigned QFE_MAX_FEATURES    = 1024;
    localparam int unsigned QFE_MAX_ROW_ENTRIES = 31;

    localparam int unsigned COL_W   = 10;
    localparam int unsigned VAL_W   = 16;
    localparam int unsigned OCOL_W  = 21;
    localparam int unsigned OVAL_W  = 32;
    localparam int unsigned FC_W    = 11;
    localparam int unsigned SCALE_W = 16;
    localparam int unsigned APB_AW  = 3;
    localparam int unsigned APB_DW  = 32;

    localparam logic [FC_W-1:0]    FC_RESET    = FC_W'(1024);
    localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(32768);

    // register index, taken from paddr[2]
    localparam logic REG_FEATURE_COUNT = 1'b0;
    localparam logic REG_QUAD_SCALE    = 1'b1;

    typedef enum logic
    {
        OP_ORIG,
        OP_PROD
    } qfe_op_t;

    typedef struct packed
    {
        logic    capture;
        logic    wr_en;
        logic    issue;
        qfe_op_t op;
        logic    use_mem;
        logic    swap;
        logic    last;
        logic    row_done;
    } qfe_cmd_t;

    typedef struct packed
    {
        logic adv;
    } qfe_stat_t;

endpackage

// ===== design/qfe_if.sv =====
// qfe_if: valid/ready channel interfaces for input entries and result words.
// Depends on qfe_pkg for the field widths.
interface qfe_entry_if;
    logic                               valid;
    logic                               ready;
    logic [qfe_pkg::COL_W-1:0]          column;
    logic signed [qfe_pkg::VAL_W-1:0]   value;
    logic                               row_end;

    modport source (output valid, column, value, row_end, input ready);
    modport sink   (input valid, column, value, row_end, output ready);
endinterface

interface qfe_result_if;
    logic                               valid;
    logic                               ready;
    logic [qfe_pkg::OCOL_W-1:0]         out_column;
    logic signed [qfe_pkg::OVAL_W-1:0]  out_value;
    logic                               run_last;
    logic                               row_done;

    modport source (output valid, out_column, out_value, run_last, row_done, input ready);
    modport sink   (input valid, out_column, out_value, run_last, row_done, output ready);
endinterface

// ===== design/qfe_ctrl.sv =====
// qfe_ctrl: sequencer (uses qfe_pkg) that walks the stored entries of the
// row for each accepted entry, issuing one result op per unstalled cycle.
module qfe_ctrl #(
    parameter int unsigned MAX_ROW_ENTRIES = qfe_pkg::QFE_MAX_ROW_ENTRIES
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 entry_valid,
    input  logic                 entry_row_end,
    output logic                 entry_ready,
    input  qfe_pkg::qfe_stat_t   stat,
    output qfe_pkg::qfe_cmd_t    cmd,
    output logic [((MAX_ROW_ENTRIES > 1) ? $clog2(MAX_ROW_ENTRIES) : 1)-1:0] rd_addr,
    output logic [((MAX_ROW_ENTRIES > 1) ? $clog2(MAX_ROW_ENTRIES) : 1)-1:0] wr_addr
);
    import qfe_pkg::*;

    localparam int unsigned CW = $clog2(MAX_ROW_ENTRIES + 1);
    localparam int unsigned AW = (MAX_ROW_ENTRIES > 1) ? $clog2(MAX_ROW_ENTRIES) : 1;

    typedef enum logic [2:0]
    {
        S_IDLE,
        S_ORIG,
        S_PAIR,
        S_SWAP,
        S_SQUARE
    } state_t;

    state_t          state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [CW-1:0]   k_reg, k_next;
    logic [CW-1:0]   e_reg, e_next;
    logic            full_reg, full_next;
    logic            row_end_reg, row_end_next;
    logic            accept;
    logic            count_full;

    assign entry_ready = (state_reg == S_IDLE);
    assign accept      = entry_ready && entry_valid;
    assign count_full  = (count_reg >= CW'(MAX_ROW_ENTRIES));
    assign rd_addr     = e_reg[AW-1:0];
    assign wr_addr     = count_reg[AW-1:0];

    always_comb
    begin
        cmd          = '0;
        cmd.op       = OP_ORIG;
        cmd.capture  = accept;
        cmd.wr_en    = accept && !entry_row_end && !count_full;
        case (state_reg)
            S_ORIG:
            begin
                cmd.issue = stat.adv;
                cmd.last  = full_reg;
            end
            S_PAIR:
            begin
                cmd.issue   = stat.adv;
                cmd.op      = OP_PROD;
                cmd.use_mem = 1'b1;
            end
            S_SWAP:
            begin
                cmd.issue   = stat.adv;
                cmd.op      = OP_PROD;
                cmd.use_mem = 1'b1;
                cmd.swap    = 1'b1;
            end
            S_SQUARE:
            begin
                cmd.issue = stat.adv;
                cmd.op    = OP_PROD;
                cmd.last  = 1'b1;
            end
            default:
            begin
                cmd.issue = 1'b0;
            end
        endcase
        cmd.row_done = cmd.last && row_end_reg;
    end

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        k_next       = k_reg;
        e_next       = e_reg;
        full_next    = full_reg;
        row_end_next = row_end_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    k_next       = count_reg;
                    full_next    = count_full;
                    row_end_next = entry_row_end;
                    e_next       = '0;
                    state_next   = S_ORIG;
                    if (entry_row_end)
                    begin
                        count_next = '0;
                    end
                    else if (!count_full)
                    begin
                        count_next = count_reg + CW'(1);
                    end
                end
            end
            S_ORIG:
            begin
                if (stat.adv)
                begin
                    if (full_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else if (k_reg == '0)
                    begin
                        state_next = S_SQUARE;
                    end
                    else
                    begin
                        state_next = S_PAIR;
                    end
                end
            end
            S_PAIR:
            begin
                if (stat.adv)
                begin
                    state_next = S_SWAP;
                end
            end
            S_SWAP:
            begin
                if (stat.adv)
                begin
                    if (e_reg == k_reg - CW'(1))
                    begin
                        state_next = S_SQUARE;
                    end
                    else
                    begin
                        e_next     = e_reg + CW'(1);
                        state_next = S_PAIR;
                    end
                end
            end
            S_SQUARE:
            begin
                if (stat.adv)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            k_reg       <= '0;
            e_reg       <= '0;
            full_reg    <= 1'b0;
            row_end_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            k_reg       <= k_next;
            e_reg       <= e_next;
            full_reg    <= full_next;
            row_end_reg <= row_end_next;
        end
    end

endmodule

// ===== design/qfe_dp.sv =====
// qfe_dp: entry store, product and column pipeline, and output register.
// Driven by qfe_ctrl commands; uses qfe_pkg.
module qfe_dp #(
    parameter int unsigned MAX_ROW_ENTRIES = qfe_pkg::QFE_MAX_ROW_ENTRIES
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  qfe_pkg::qfe_cmd_t                   cmd,
    output qfe_pkg::qfe_stat_t                  stat,
    input  logic [((MAX_ROW_ENTRIES > 1) ? $clog2(MAX_ROW_ENTRIES) : 1)-1:0] rd_addr,
    input  logic [((MAX_ROW_ENTRIES > 1) ? $clog2(MAX_ROW_ENTRIES) : 1)-1:0] wr_addr,
    input  logic [qfe_pkg::COL_W-1:0]           column,
    input  logic signed [qfe_pkg::VAL_W-1:0]    value,
    input  logic [qfe_pkg::FC_W-1:0]            feature_count,
    input  logic [qfe_pkg::SCALE_W-1:0]         quad_scale,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [qfe_pkg::OCOL_W-1:0]          out_column,
    output logic signed [qfe_pkg::OVAL_W-1:0]   out_value,
    output logic                                run_last,
    output logic                                row_done
);
    import qfe_pkg::*;

    localparam int unsigned QW = FC_W + COL_W + 2;
    localparam int unsigned PW = OVAL_W + SCALE_W + 1;

    logic [COL_W-1:0]         mem_col [MAX_ROW_ENTRIES];
    logic signed [VAL_W-1:0]  mem_val [MAX_ROW_ENTRIES];

    logic                     adv;
    logic [FC_W-1:0]          n_reg, n_next;
    logic [COL_W-1:0]         cur_col_reg;
    logic signed [VAL_W-1:0]  cur_val_reg;
    logic [COL_W-1:0]         rd_col_reg;
    logic signed [VAL_W-1:0]  rd_val_reg;

    // stage 1: operands
    logic                     s1_valid_reg;
    qfe_op_t                  s1_op_reg;
    logic                     s1_use_mem_reg, s1_swap_reg, s1_last_reg, s1_done_reg;
    logic [COL_W-1:0]         s1_col_reg;
    logic signed [VAL_W-1:0]  s1_val_reg;

    // stage 2: raw product and column
    logic                     s2_valid_reg;
    qfe_op_t                  s2_op_reg;
    logic                     s2_last_reg, s2_done_reg;
    logic [OCOL_W-1:0]        s2_col_reg;
    logic signed [OVAL_W-1:0] s2_p_reg;

    // stage 3: scaled product
    logic                     s3_valid_reg;
    qfe_op_t                  s3_op_reg;
    logic                     s3_last_reg, s3_done_reg;
    logic [OCOL_W-1:0]        s3_col_reg;
    logic signed [OVAL_W-1:0] s3_p_reg;
    logic signed [PW-1:0]     s3_t_reg;

    logic                     out_valid_reg;
    logic [OCOL_W-1:0]        out_col_reg;
    logic signed [OVAL_W-1:0] out_val_reg;
    logic                     out_last_reg, out_done_reg;

    logic signed [VAL_W-1:0]  op_b;
    logic [COL_W-1:0]         col_i, col_j;
    logic [COL_W:0]           col_i1;
    logic [QW-1:0]            qcol;
    logic signed [OVAL_W-1:0] prod, orig_v;
    logic signed [PW-1:0]     t_comb, rnd, shifted;
    logic [PW-OVAL_W:0]       hi;
    logic signed [OVAL_W-1:0] sat_v;

    assign adv      = !out_valid_reg || out_ready;
    assign stat.adv = adv;

    always_comb
    begin
        if (feature_count == '0)
        begin
            n_next = FC_W'(1);
        end
        else if (32'(feature_count) > QFE_MAX_FEATURES)
        begin
            n_next = FC_W'(QFE_MAX_FEATURES);
        end
        else
        begin
            n_next = feature_count;
        end
    end

    // entry store, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem_col[wr_addr] <= column;
            mem_val[wr_addr] <= value;
        end
        if (adv && cmd.issue)
        begin
            rd_col_reg <= mem_col[rd_addr];
            rd_val_reg <= mem_val[rd_addr];
        end
    end

    always_comb
    begin
        op_b   = s1_use_mem_reg ? rd_val_reg : s1_val_reg;
        col_i  = s1_swap_reg ? rd_col_reg : s1_col_reg;
        col_j  = s1_swap_reg ? s1_col_reg : (s1_use_mem_reg ? rd_col_reg : s1_col_reg);
        col_i1 = {1'b0, col_i} + (COL_W+1)'(1);
        qcol   = QW'(n_reg) * QW'(col_i1) + QW'(col_j);
        prod   = OVAL_W'(s1_val_reg) * OVAL_W'(op_b);
        orig_v = {{(OVAL_W-VAL_W-12){s1_val_reg[VAL_W-1]}}, s1_val_reg, 12'b0};
    end

    assign t_comb = PW'(s2_p_reg) * PW'($signed({1'b0, quad_scale}));

    // round half up, then saturate to the output range
    always_comb
    begin
        rnd     = s3_t_reg + PW'(16384);
        shifted = rnd >>> 15;
        hi      = shifted[PW-1:OVAL_W-1];
        if ((&hi) || !(|hi))
        begin
            sat_v = shifted[OVAL_W-1:0];
        end
        else if (shifted[PW-1])
        begin
            sat_v = {1'b1, {(OVAL_W-1){1'b0}}};
        end
        else
        begin
            sat_v = {1'b0, {(OVAL_W-1){1'b1}}};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= cmd.issue;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            out_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg <= n_next;
        if (cmd.capture)
        begin
            cur_col_reg <= column;
            cur_val_reg <= value;
        end
        if (adv)
        begin
            s1_op_reg      <= cmd.op;
            s1_use_mem_reg <= cmd.use_mem;
            s1_swap_reg    <= cmd.swap;
            s1_last_reg    <= cmd.last;
            s1_done_reg    <= cmd.row_done;
            s1_col_reg     <= cur_col_reg;
            s1_val_reg     <= cur_val_reg;

            s2_op_reg      <= s1_op_reg;
            s2_last_reg    <= s1_last_reg;
            s2_done_reg    <= s1_done_reg;
            s2_col_reg     <= (s1_op_reg == OP_ORIG) ? OCOL_W'(s1_col_reg) : qcol[OCOL_W-1:0];
            s2_p_reg       <= (s1_op_reg == OP_ORIG) ? orig_v : prod;

            s3_op_reg      <= s2_op_reg;
            s3_last_reg    <= s2_last_reg;
            s3_done_reg    <= s2_done_reg;
            s3_col_reg     <= s2_col_reg;
            s3_p_reg       <= s2_p_reg;
            s3_t_reg       <= t_comb;

            out_col_reg    <= s3_col_reg;
            out_val_reg    <= (s3_op_reg == OP_ORIG) ? s3_p_reg : sat_v;
            out_last_reg   <= s3_last_reg;
            out_done_reg   <= s3_done_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_column = out_col_reg;
    assign out_value  = out_val_reg;
    assign run_last   = out_last_reg;
    assign row_done   = out_done_reg;

endmodule

// ===== design/quadratic_feature_expansion_core.sv =====
// Degree-2 feature expansion of sparse rows. An entry (column, value) with k
// earlier entries stored for its row yields 2k+2 result words: the entry
// itself, the products with each stored entry in both orders, then its
// square; with the row store full it yields the entry alone. One result word
// leaves per cycle while the sink takes them; the sequencer walks the
// 31-entry row store through its single read port and accepts no new entry
// until the last word of an entry is issued. Words pass stage 1, stage 2,
// stage 3 and the output register. Products are scaled by quad_scale
// (unsigned Q1.15), rounded half up and saturated to Q8.24. The row store
// needs no clearing after reset. Uses qfe_pkg, qfe_if, qfe_ctrl and qfe_dp.
module quadratic_feature_expansion_core #(
    parameter int unsigned MAX_ROW_ENTRIES = qfe_pkg::QFE_MAX_ROW_ENTRIES
) (
    input  logic                          clk,
    input  logic                          rst_n,
    qfe_entry_if.sink                     entry,
    qfe_result_if.source                  result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [qfe_pkg::APB_AW-1:0]    paddr,
    input  logic [qfe_pkg::APB_DW-1:0]    pwdata,
    output logic [qfe_pkg::APB_DW-1:0]    prdata,
    output logic                          pready
);
    import qfe_pkg::*;

    localparam int unsigned AW = (MAX_ROW_ENTRIES > 1) ? $clog2(MAX_ROW_ENTRIES) : 1;

    logic [FC_W-1:0]    fc_reg;
    logic [SCALE_W-1:0] scale_reg;
    logic               cfg_we;
    qfe_cmd_t           cmd;
    qfe_stat_t          stat;
    logic [AW-1:0]      rd_addr, wr_addr;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fc_reg    <= FC_RESET;
            scale_reg <= SCALE_RESET;
        end
        else if (cfg_we)
        begin
            case (paddr[2])
                REG_FEATURE_COUNT: fc_reg    <= pwdata[FC_W-1:0];
                REG_QUAD_SCALE:    scale_reg <= pwdata[SCALE_W-1:0];
                default:           fc_reg    <= fc_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_FEATURE_COUNT: prdata = APB_DW'(fc_reg);
            REG_QUAD_SCALE:    prdata = APB_DW'(scale_reg);
            default:           prdata = '0;
        endcase
    end

    qfe_ctrl #(
        .MAX_ROW_ENTRIES (MAX_ROW_ENTRIES)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .entry_valid   (entry.valid),
        .entry_row_end (entry.row_end),
        .entry_ready   (entry.ready),
        .stat          (stat),
        .cmd           (cmd),
        .rd_addr       (rd_addr),
        .wr_addr       (wr_addr)
    );

    qfe_dp #(
        .MAX_ROW_ENTRIES (MAX_ROW_ENTRIES)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .rd_addr       (rd_addr),
        .wr_addr       (wr_addr),
        .column        (entry.column),
        .value         (entry.value),
        .feature_count (fc_reg),
        .quad_scale    (scale_reg),
        .out_valid     (result.valid),
        .out_ready     (result.ready),
        .out_column    (result.out_column),
        .out_value     (result.out_value),
        .run_last      (result.run_last),
        .row_done      (result.row_done)
    );

endmodule

// ===== design/qfe_checker.sv =====
// qfe_checker: port-level checks on the expansion core, attached by bind.
// Uses qfe_pkg for the field widths.
module qfe_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               entry_valid,
    input logic                               entry_ready,
    input logic                               result_valid,
    input logic                               result_ready,
    input logic [qfe_pkg::OCOL_W-1:0]         out_column,
    input logic signed [qfe_pkg::OVAL_W-1:0]  out_value,
    input logic                               run_last,
    input logic                               row_done
);

    // a stalled result word holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(out_column)
            && $stable(out_value) && $stable(run_last) && $stable(row_done))
        else $error("result word changed while stalled");

    // one entry at a time: ready drops after an acceptance
    a_one_entry: assert property (@(posedge clk) disable iff (!rst_n)
        entry_valid && entry_ready |=> !entry_ready)
        else $error("entry accepted while previous entry still in work");

    // the end of a row only marks the last word of an entry
    a_row_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && row_done |-> run_last)
        else $error("row_done without run_last");

endmodule

bind quadratic_feature_expansion_core qfe_checker u_qfe_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .entry_valid  (entry.valid),
    .entry_ready  (entry.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .out_column   (result.out_column),
    .out_value    (result.out_value),
    .run_last     (result.run_last),
    .row_done     (result.row_done)
);
